[sv/depth_pixel_ground_classifier_macros.svh]
// Assertion helpers for the depth pixel ground classifier.
`ifndef DEPTH_PIXEL_GROUND_CLASSIFIER_MACROS_SVH
`define DEPTH_PIXEL_GROUND_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF
`define DPGC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DPGC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPGC_ASSERT(lbl, clk, rst, prop, msg)
`define DPGC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[sv/dpgc_pkg.sv]
package dpgc_pkg;

   // register map of the csr write channel
   typedef enum logic [2:0] {
      REG_FOCAL_LENGTH  = 3'd0,
      REG_CAMERA_HEIGHT = 3'd1,
      REG_CAND_LIMIT    = 3'd2,
      REG_PLANE_A       = 3'd3,
      REG_PLANE_B       = 3'd4,
      REG_PLANE_C       = 3'd5,
      REG_PLANE_D       = 3'd6
   } csr_index_type;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DEPTH_W = 16;
   localparam int PIX_W = 10;

   localparam logic [15:0] DEPTH_MIN = 16'd500;
   localparam logic [15:0] DEPTH_INF = 16'hFFFF;

   // (rows - 2*row) and (2*col - cols) fit 12 bit signed for images up to 1024
   localparam int COORD_W = 12;
   localparam int PROD_W = COORD_W + DEPTH_W + 1;
   localparam int MAG_W = 27;
   // dividend 2*|n*8| + f, below 2^31
   localparam int DIV_W = 31;
   localparam int DVSR_W = 17;
   localparam int DIV_STAGES = DIV_W;

   localparam int RAW_W = 32;
   localparam int HGT_W = 33;
   localparam int NEAR_W = 34;
   localparam int PA_W = 33;
   localparam int PB_W = 48;
   localparam int LHS_W = 49;
   localparam int CMP_W = 50;

   localparam logic [15:0] RST_FOCAL  = 16'd8400;
   localparam logic [15:0] RST_CAMH   = 16'd300;
   localparam logic [15:0] RST_LIMIT  = 16'd100;
   localparam logic [15:0] RST_A      = 16'hFAE1; // -1311
   localparam logic [15:0] RST_B      = 16'd0;
   localparam logic [15:0] RST_C      = 16'd16384;
   localparam logic [15:0] RST_D      = 16'd100;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic               dok;
      logic               rowlow;
      logic               neg_h;
      logic               neg_l;
   } side_type;

   function automatic logic signed [15:0] sat16(input logic signed [HGT_W-1:0] v);
      logic signed [15:0] r;
      if (v > 33'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -33'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

[sv/depth_pixel_ground_classifier.sv]
// Pipeline: 37 register stages; rsp_strobe is high for exactly one cycle per transaction.
// Throughput: one transaction per clock while busy is low; the receiver cannot stall.
// Most of the pipeline is the two restoring dividers, one quotient bit per stage (31 stages).
// Reset (synchronous): pipeline valids clear, csr registers take their defaults; busy is a
// registered copy of reset, and csr_ready (its inverse) is held off while busy is high.
`include "depth_pixel_ground_classifier_macros.svh"

module depth_pixel_ground_classifier
   import dpgc_pkg::*;
#(
   parameter int IMG_ROWS = 480,
   parameter int IMG_COLS = 640
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [DEPTH_W-1:0]       req_depth,
   input  logic [PIX_W-1:0]         req_pixel_row,
   input  logic [PIX_W-1:0]         req_pixel_col,
   output logic                     rsp_strobe,
   output logic                     rsp_obstacle,
   output logic                     rsp_ground_candidate,
   output logic [DEPTH_W-1:0]       rsp_point_forward,
   output logic signed [15:0]       rsp_point_lateral,
   output logic signed [15:0]       rsp_point_height,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PIPE_DEPTH = 3 + DIV_STAGES + 3;
   localparam int ROW_HALF = IMG_ROWS / 2;

   // ---------------- control / csr ----------------
   logic busy_ff, busy_in;
   logic accept;

   logic [15:0]        focal_ff, focal_in;
   logic signed [15:0] camh_ff, camh_in;
   logic [15:0]        limit_ff, limit_in;
   logic signed [15:0] pa_ff, pa_in;
   logic signed [15:0] pb_ff, pb_in;
   logic signed [15:0] pc_ff, pc_in;
   logic signed [15:0] pd_ff, pd_in;

   logic [15:0]        f_eff;
   logic [DVSR_W-1:0]  dvsr;

   assign busy_in = reset;
   assign busy = busy_ff;
   assign csr_ready = !busy_ff;
   assign accept = start && !busy_ff;

   assign f_eff = (focal_ff == 16'd0) ? 16'd1 : focal_ff;
   assign dvsr = {f_eff, 1'b0};

   always_comb begin
      focal_in = focal_ff;
      camh_in = camh_ff;
      limit_in = limit_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      pc_in = pc_ff;
      pd_in = pd_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_FOCAL_LENGTH:  focal_in = csr_wdata;
            REG_CAMERA_HEIGHT: camh_in = csr_wdata;
            REG_CAND_LIMIT:    limit_in = csr_wdata;
            REG_PLANE_A:       pa_in = csr_wdata;
            REG_PLANE_B:       pb_in = csr_wdata;
            REG_PLANE_C:       pc_in = csr_wdata;
            REG_PLANE_D:       pd_in = csr_wdata;
            default:           ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
      if (reset) begin
         focal_ff <= RST_FOCAL;
         camh_ff <= RST_CAMH;
         limit_ff <= RST_LIMIT;
         pa_ff <= RST_A;
         pb_ff <= RST_B;
         pc_ff <= RST_C;
         pd_ff <= RST_D;
      end else begin
         focal_ff <= focal_in;
         camh_ff <= camh_in;
         limit_ff <= limit_in;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         pc_ff <= pc_in;
         pd_ff <= pd_in;
      end
   end

   // ---------------- stage 0: capture ----------------
   logic             s0_valid_ff, s0_valid_in;
   logic [DEPTH_W-1:0] s0_depth_ff, s0_depth_in;
   logic [PIX_W-1:0] s0_row_ff, s0_row_in;
   logic [PIX_W-1:0] s0_col_ff, s0_col_in;

   assign s0_valid_in = accept;
   assign s0_depth_in = req_depth;
   assign s0_row_in = req_pixel_row;
   assign s0_col_in = req_pixel_col;

   // ---------------- stage 1: image offsets times depth ----------------
   logic                      s1_valid_ff, s1_valid_in;
   logic [DEPTH_W-1:0]        s1_depth_ff, s1_depth_in;
   logic                      s1_dok_ff, s1_dok_in;
   logic                      s1_rowlow_ff, s1_rowlow_in;
   logic signed [PROD_W-1:0]  s1_prod_h_ff, s1_prod_h_in;
   logic signed [PROD_W-1:0]  s1_prod_l_ff, s1_prod_l_in;

   always_comb begin
      logic signed [COORD_W-1:0] nh;
      logic signed [COORD_W-1:0] nl;
      logic signed [DEPTH_W:0]   z;
      nh = $signed(COORD_W'(IMG_ROWS)) - $signed({1'b0, s0_row_ff, 1'b0});
      nl = $signed({1'b0, s0_col_ff, 1'b0}) - $signed(COORD_W'(IMG_COLS));
      z = $signed({1'b0, s0_depth_ff});
      s1_valid_in = s0_valid_ff;
      s1_depth_in = s0_depth_ff;
      s1_dok_in = (s0_depth_ff > DEPTH_MIN) && (s0_depth_ff != DEPTH_INF);
      s1_rowlow_in = {1'b0, s0_row_ff} > (PIX_W + 1)'(ROW_HALF);
      s1_prod_h_in = nh * z;
      s1_prod_l_in = nl * z;
   end

   // ---------------- divider pipeline ----------------
   // entry 0 holds the loaded dividends, entries 1..DIV_STAGES one quotient bit each
   logic                dv_valid_ff [DIV_STAGES+1];
   logic                dv_valid_in [DIV_STAGES+1];
   side_type            dv_side_ff [DIV_STAGES+1];
   side_type            dv_side_in [DIV_STAGES+1];
   logic [DVSR_W-1:0]   dv_rem_ff [2][DIV_STAGES+1];
   logic [DVSR_W-1:0]   dv_rem_in [2][DIV_STAGES+1];
   logic [DIV_W-1:0]    dv_nq_ff [2][DIV_STAGES+1];
   logic [DIV_W-1:0]    dv_nq_in [2][DIV_STAGES+1];

   always_comb begin
      logic [PROD_W-1:0] mag_h;
      logic [PROD_W-1:0] mag_l;
      logic [DVSR_W:0]   trial;
      logic              qbit;
      mag_h = s1_prod_h_ff[PROD_W-1] ? PROD_W'(-s1_prod_h_ff) : PROD_W'(s1_prod_h_ff);
      mag_l = s1_prod_l_ff[PROD_W-1] ? PROD_W'(-s1_prod_l_ff) : PROD_W'(s1_prod_l_ff);

      // dividend 2*|n*8| + f against divisor 2*f gives round half away
      dv_valid_in[0] = s1_valid_ff;
      dv_side_in[0].depth = s1_depth_ff;
      dv_side_in[0].dok = s1_dok_ff;
      dv_side_in[0].rowlow = s1_rowlow_ff;
      dv_side_in[0].neg_h = s1_prod_h_ff[PROD_W-1];
      dv_side_in[0].neg_l = s1_prod_l_ff[PROD_W-1];
      dv_rem_in[0][0] = '0;
      dv_rem_in[1][0] = '0;
      dv_nq_in[0][0] = DIV_W'({mag_h[MAG_W-1:0], 4'b0000}) + DIV_W'(f_eff);
      dv_nq_in[1][0] = DIV_W'({mag_l[MAG_W-1:0], 4'b0000}) + DIV_W'(f_eff);

      for (int k = 0; k < DIV_STAGES; k++) begin
         dv_valid_in[k+1] = dv_valid_ff[k];
         dv_side_in[k+1] = dv_side_ff[k];
         for (int j = 0; j < 2; j++) begin
            trial = {dv_rem_ff[j][k], dv_nq_ff[j][k][DIV_W-1]};
            qbit = trial >= {1'b0, dvsr};
            if (qbit) begin
               dv_rem_in[j][k+1] = DVSR_W'(trial - {1'b0, dvsr});
            end else begin
               dv_rem_in[j][k+1] = trial[DVSR_W-1:0];
            end
            dv_nq_in[j][k+1] = {dv_nq_ff[j][k][DIV_W-2:0], qbit};
         end
      end
   end

   // ---------------- post 1: signs and camera offset ----------------
   logic                     p1_valid_ff, p1_valid_in;
   side_type                 p1_side_ff, p1_side_in;
   logic signed [RAW_W-1:0]  p1_raw_l_ff, p1_raw_l_in;
   logic signed [HGT_W-1:0]  p1_height_ff, p1_height_in;

   always_comb begin
      logic signed [RAW_W-1:0] qh;
      logic signed [RAW_W-1:0] ql;
      logic signed [RAW_W-1:0] raw_h;
      qh = $signed({1'b0, dv_nq_ff[0][DIV_STAGES]});
      ql = $signed({1'b0, dv_nq_ff[1][DIV_STAGES]});
      raw_h = dv_side_ff[DIV_STAGES].neg_h ? -qh : qh;
      // lateral axis points opposite to the column axis
      p1_raw_l_in = dv_side_ff[DIV_STAGES].neg_l ? ql : -ql;
      p1_height_in = HGT_W'(raw_h) + HGT_W'(camh_ff);
      p1_valid_in = dv_valid_ff[DIV_STAGES];
      p1_side_in = dv_side_ff[DIV_STAGES];
   end

   // ---------------- post 2: plane products, candidate, saturation ----------------
   logic                     p2_valid_ff, p2_valid_in;
   logic [DEPTH_W-1:0]       p2_depth_ff, p2_depth_in;
   logic                     p2_dok_ff, p2_dok_in;
   logic signed [PA_W-1:0]   p2_prod_a_ff, p2_prod_a_in;
   logic signed [PB_W-1:0]   p2_prod_b_ff, p2_prod_b_in;
   logic signed [LHS_W-1:0]  p2_lhs_ff, p2_lhs_in;
   logic                     p2_cand_ff, p2_cand_in;
   logic signed [15:0]       p2_lat_ff, p2_lat_in;
   logic signed [15:0]       p2_hgt_ff, p2_hgt_in;

   always_comb begin
      logic signed [NEAR_W-1:0] near;
      logic [NEAR_W-1:0]        near_abs;
      near = NEAR_W'(p1_height_ff) + NEAR_W'(camh_ff);
      near_abs = near[NEAR_W-1] ? NEAR_W'(-near) : NEAR_W'(near);
      p2_valid_in = p1_valid_ff;
      p2_depth_in = p1_side_ff.depth;
      p2_dok_in = p1_side_ff.dok;
      p2_prod_a_in = pa_ff * $signed({1'b0, p1_side_ff.depth});
      p2_prod_b_in = pb_ff * p1_raw_l_ff;
      p2_lhs_in = p1_height_ff * pc_ff;
      p2_cand_in = p1_side_ff.dok && p1_side_ff.rowlow &&
                   (near_abs < NEAR_W'(limit_ff));
      p2_lat_in = sat16(HGT_W'(p1_raw_l_ff));
      p2_hgt_in = sat16(p1_height_ff);
   end

   // ---------------- post 3: plane compare, result register ----------------
   logic                 out_strobe_ff, out_strobe_in;
   logic                 out_obst_ff, out_obst_in;
   logic                 out_cand_ff, out_cand_in;
   logic [DEPTH_W-1:0]   out_fwd_ff, out_fwd_in;
   logic signed [15:0]   out_lat_ff, out_lat_in;
   logic signed [15:0]   out_hgt_ff, out_hgt_in;

   always_comb begin
      logic signed [CMP_W-1:0] rhs;
      logic signed [CMP_W-1:0] lhs;
      logic                    above;
      rhs = -CMP_W'(p2_prod_a_ff) - CMP_W'(p2_prod_b_ff) - (CMP_W'(pd_ff) <<< 14);
      lhs = CMP_W'(p2_lhs_ff);
      // c below zero flips the inequality, c of zero never flags
      if (pc_ff > 16'sd0) begin
         above = lhs > rhs;
      end else if (pc_ff < 16'sd0) begin
         above = lhs < rhs;
      end else begin
         above = 1'b0;
      end
      out_strobe_in = p2_valid_ff;
      out_obst_in = p2_dok_ff && above;
      out_cand_in = p2_cand_ff;
      out_fwd_in = p2_depth_ff;
      out_lat_in = p2_dok_ff ? p2_lat_ff : 16'sd0;
      out_hgt_in = p2_dok_ff ? p2_hgt_ff : 16'sd0;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         for (int k = 0; k <= DIV_STAGES; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         for (int k = 0; k <= DIV_STAGES; k++) begin
            dv_valid_ff[k] <= dv_valid_in[k];
         end
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
         out_strobe_ff <= out_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_depth_ff <= s0_depth_in;
      s0_row_ff <= s0_row_in;
      s0_col_ff <= s0_col_in;
      s1_depth_ff <= s1_depth_in;
      s1_dok_ff <= s1_dok_in;
      s1_rowlow_ff <= s1_rowlow_in;
      s1_prod_h_ff <= s1_prod_h_in;
      s1_prod_l_ff <= s1_prod_l_in;
      for (int k = 0; k <= DIV_STAGES; k++) begin
         dv_side_ff[k] <= dv_side_in[k];
         for (int j = 0; j < 2; j++) begin
            dv_rem_ff[j][k] <= dv_rem_in[j][k];
            dv_nq_ff[j][k] <= dv_nq_in[j][k];
         end
      end
      p1_side_ff <= p1_side_in;
      p1_raw_l_ff <= p1_raw_l_in;
      p1_height_ff <= p1_height_in;
      p2_depth_ff <= p2_depth_in;
      p2_dok_ff <= p2_dok_in;
      p2_prod_a_ff <= p2_prod_a_in;
      p2_prod_b_ff <= p2_prod_b_in;
      p2_lhs_ff <= p2_lhs_in;
      p2_cand_ff <= p2_cand_in;
      p2_lat_ff <= p2_lat_in;
      p2_hgt_ff <= p2_hgt_in;
      out_obst_ff <= out_obst_in;
      out_cand_ff <= out_cand_in;
      out_fwd_ff <= out_fwd_in;
      out_lat_ff <= out_lat_in;
      out_hgt_ff <= out_hgt_in;
   end

   assign rsp_strobe = out_strobe_ff;
   assign rsp_obstacle = out_obst_ff;
   assign rsp_ground_candidate = out_cand_ff;
   assign rsp_point_forward = out_fwd_ff;
   assign rsp_point_lateral = out_lat_ff;
   assign rsp_point_height = out_hgt_ff;

   // ---------------- assertions ----------------
   `DPGC_ASSERT(a_fixed_latency, clock, reset, accept |-> ##PIPE_DEPTH rsp_strobe, "transaction lost in pipeline")
   `DPGC_ASSERT(a_no_spurious, clock, reset, rsp_strobe |-> $past(accept, PIPE_DEPTH), "result without transaction")
   `DPGC_ASSERT(a_forward_depth, clock, reset, rsp_strobe |-> rsp_point_forward == $past(req_depth, PIPE_DEPTH), "forward coordinate mismatch")
   `DPGC_ASSERT(a_invalid_zero, clock, reset, rsp_strobe && (rsp_point_forward <= DEPTH_MIN || rsp_point_forward == DEPTH_INF) |-> !rsp_obstacle && !rsp_ground_candidate && rsp_point_lateral == 16'sd0 && rsp_point_height == 16'sd0, "invalid depth not cleared")
   `DPGC_ASSERT(a_cand_lower_half, clock, reset, rsp_strobe && rsp_ground_candidate |-> {1'b0, $past(req_pixel_row, PIPE_DEPTH)} > (PIX_W + 1)'(ROW_HALF), "candidate in upper half")

endmodule

[tb/tb.sv]
module tb;
   import dpgc_pkg::*;

   localparam int ROWS = 480;
   localparam int COLS = 640;
   localparam int IDLE_LIMIT = 1000;
   // index 7 has no register behind it; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic               obstacle;
      logic               ground_candidate;
      logic [15:0]        forward;
      logic signed [15:0] lateral;
      logic signed [15:0] height;
   } point_class_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [DEPTH_W-1:0]    req_depth;
   logic [PIX_W-1:0]      req_pixel_row;
   logic [PIX_W-1:0]      req_pixel_col;
   logic                  rsp_strobe;
   logic                  rsp_obstacle;
   logic                  rsp_ground_candidate;
   logic [DEPTH_W-1:0]    rsp_point_forward;
   logic signed [15:0]    rsp_point_lateral;
   logic signed [15:0]    rsp_point_height;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // shadow copy of the register file
   logic [15:0]        focal_len;
   logic signed [15:0] cam_height;
   logic [15:0]        cand_limit;
   logic signed [15:0] plane_a;
   logic signed [15:0] plane_b;
   logic signed [15:0] plane_c;
   logic signed [15:0] plane_d;

   point_class_type expected_points[$];
   int errors;
   int pixels_sent;
   int points_checked;
   int settings_used;
   int burst_left;
   int gap_max;
   int idle_cycles;

   depth_pixel_ground_classifier #(
      .IMG_ROWS(ROWS),
      .IMG_COLS(COLS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_depth(req_depth),
      .req_pixel_row(req_pixel_row),
      .req_pixel_col(req_pixel_col),
      .rsp_strobe(rsp_strobe),
      .rsp_obstacle(rsp_obstacle),
      .rsp_ground_candidate(rsp_ground_candidate),
      .rsp_point_forward(rsp_point_forward),
      .rsp_point_lateral(rsp_point_lateral),
      .rsp_point_height(rsp_point_height),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // n / d to nearest, ties away from zero, d > 0
   function automatic longint round_div(input longint n, input longint d);
      if (n >= 0) begin
         return (2 * n + d) / (2 * d);
      end
      return -((-2 * n + d) / (2 * d));
   endfunction

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end else if (v < -32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic point_class_type classify_point(input logic [15:0] depth,
                                                      input logic [9:0] row,
                                                      input logic [9:0] col);
      point_class_type r;
      longint z, f, raw_h, raw_l, hgt, rhs, lhs, near_gnd, pc;
      r = '0;
      r.forward = depth;
      z = longint'(depth);
      f = (focal_len == 0) ? 1 : longint'(focal_len);
      pc = longint'(plane_c);
      if (depth > DEPTH_MIN && depth != DEPTH_INF) begin
         raw_h = round_div((ROWS - 2 * longint'(row)) * z * 8, f);
         raw_l = -round_div((2 * longint'(col) - COLS) * z * 8, f);
         hgt = raw_h + longint'(cam_height);
         rhs = -longint'(plane_a) * z - longint'(plane_b) * raw_l
               - longint'(plane_d) * 16384;
         lhs = hgt * pc;
         if (pc > 0) begin
            r.obstacle = lhs > rhs;
         end else if (pc < 0) begin
            r.obstacle = lhs < rhs;
         end
         near_gnd = hgt + longint'(cam_height);
         if (near_gnd < 0) begin
            near_gnd = -near_gnd;
         end
         r.ground_candidate = (longint'(row) > ROWS / 2) &&
                              (near_gnd < longint'(cand_limit));
         r.lateral = clamp16(raw_l);
         r.height = clamp16(hgt);
      end
      return r;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_FOCAL_LENGTH:  focal_len = data;
         REG_CAMERA_HEIGHT: cam_height = data;
         REG_CAND_LIMIT:    cand_limit = data;
         REG_PLANE_A:       plane_a = data;
         REG_PLANE_B:       plane_b = data;
         REG_PLANE_C:       plane_c = data;
         REG_PLANE_D:       plane_d = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sender works in bursts; start stays high across back-to-back transactions
   task automatic send_pixel(input logic [15:0] depth, input logic [9:0] row,
                             input logic [9:0] col);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      start <= 1'b1;
      req_depth <= depth;
      req_pixel_row <= row;
      req_pixel_col <= col;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_points.push_back(classify_point(depth, row, col));
      pixels_sent++;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      start <= 1'b0;
      burst_left = 0;
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   task automatic test_default_settings();
      settings_used++;
      send_pixel(16'd0, 10'd0, 10'd0);
      send_pixel(16'd500, 10'd300, 10'd320);
      send_pixel(16'd501, 10'd479, 10'd0);
      send_pixel(DEPTH_INF, 10'd479, 10'd639);
      send_pixel(16'd65534, 10'd1023, 10'd1023);
      send_pixel(16'd1000, 10'd240, 10'd320);
      send_pixel(16'd1000, 10'd241, 10'd320);
      send_pixel(16'd3000, 10'd400, 10'd100);
      send_pixel(16'd65534, 10'd0, 10'd0);
      wait_drain();
   endtask

   task automatic test_zero_focal_length();
      write_csr(REG_FOCAL_LENGTH, 16'd0);
      settings_used++;
      send_pixel(16'd65534, 10'd1023, 10'd1023);
      send_pixel(16'd600, 10'd0, 10'd0);
      send_pixel(16'd65534, 10'd480, 10'd320);
      wait_drain();
   endtask

   task automatic test_flat_plane_c();
      write_csr(REG_FOCAL_LENGTH, 16'd1);
      write_csr(REG_PLANE_C, 16'd0);
      settings_used++;
      send_pixel(16'd5000, 10'd100, 10'd700);
      send_pixel(16'd501, 10'd479, 10'd320);
      send_pixel(16'd65534, 10'd241, 10'd1);
      wait_drain();
   endtask

   task automatic test_register_extremes();
      write_csr(REG_FOCAL_LENGTH, 16'hFFFF);
      write_csr(REG_CAMERA_HEIGHT, 16'h8000);
      write_csr(REG_CAND_LIMIT, 16'hFFFF);
      write_csr(REG_PLANE_A, 16'h7FFF);
      write_csr(REG_PLANE_B, 16'h8000);
      write_csr(REG_PLANE_C, 16'h8000);
      write_csr(REG_PLANE_D, 16'h7FFF);
      settings_used++;
      send_pixel(16'd40000, 10'd1023, 10'd0);
      send_pixel(16'd800, 10'd300, 10'd1023);
      wait_drain();
      write_csr(REG_CAMERA_HEIGHT, 16'h7FFF);
      write_csr(REG_CAND_LIMIT, 16'd0);
      write_csr(REG_PLANE_A, 16'h8000);
      write_csr(REG_PLANE_B, 16'h7FFF);
      write_csr(REG_PLANE_C, 16'h7FFF);
      write_csr(REG_PLANE_D, 16'h8000);
      settings_used++;
      send_pixel(16'd20000, 10'd0, 10'd639);
      send_pixel(16'd65534, 10'd479, 10'd320);
      wait_drain();
   endtask

   task automatic test_unused_index();
      write_csr(REG_UNUSED, 16'hFFFF);
      send_pixel(16'd7000, 10'd350, 10'd200);
      send_pixel(16'd1500, 10'd50, 10'd600);
      wait_drain();
   endtask

   task automatic randomize_settings();
      logic [15:0] v;
      case ($urandom_range(0, 7))
         0: v = 16'd1;
         1: v = 16'hFFFF;
         2: v = 16'($urandom);
         default: v = 16'($urandom_range(2000, 16000));
      endcase
      write_csr(REG_FOCAL_LENGTH, v);
      case ($urandom_range(0, 7))
         0: v = 16'h8000;
         1: v = 16'h7FFF;
         2: v = 16'($urandom);
         default: v = 16'($urandom_range(0, 1500));
      endcase
      write_csr(REG_CAMERA_HEIGHT, v);
      case ($urandom_range(0, 7))
         0: v = 16'd0;
         1: v = 16'hFFFF;
         2: v = 16'($urandom);
         default: v = 16'($urandom_range(20, 600));
      endcase
      write_csr(REG_CAND_LIMIT, v);
      case ($urandom_range(0, 7))
         0: v = 16'h8000;
         1: v = 16'h7FFF;
         2: v = 16'($urandom);
         default: v = 16'(int'($urandom_range(0, 4000)) - 2000);
      endcase
      write_csr(REG_PLANE_A, v);
      case ($urandom_range(0, 7))
         0: v = 16'h8000;
         1: v = 16'h7FFF;
         2: v = 16'($urandom);
         default: v = 16'(int'($urandom_range(0, 2000)) - 1000);
      endcase
      write_csr(REG_PLANE_B, v);
      case ($urandom_range(0, 9))
         0: v = 16'h8000;
         1: v = 16'h7FFF;
         2: v = 16'd0;
         3: v = 16'($urandom);
         4: v = 16'(-int'($urandom_range(8000, 16384)));
         default: v = 16'($urandom_range(8000, 16384));
      endcase
      write_csr(REG_PLANE_C, v);
      case ($urandom_range(0, 7))
         0: v = 16'h8000;
         1: v = 16'h7FFF;
         2: v = 16'($urandom);
         default: v = 16'(int'($urandom_range(0, 600)) - 300);
      endcase
      write_csr(REG_PLANE_D, v);
      if ($urandom_range(0, 3) == 0) begin
         write_csr(REG_UNUSED, 16'($urandom));
      end
      settings_used++;
   endtask

   task automatic test_random_traffic();
      logic [15:0] depth;
      logic [9:0]  row;
      logic [9:0]  col;
      for (int phase = 0; phase < 6; phase++) begin
         // registers change only with the pipeline empty
         wait_drain();
         randomize_settings();
         gap_max = (phase == 2) ? 0 : $urandom_range(1, 8);
         for (int i = 0; i < 75; i++) begin
            case ($urandom_range(0, 9))
               0: depth = 16'($urandom_range(0, 500));
               1: depth = DEPTH_INF;
               2: depth = 16'($urandom);
               default: depth = 16'($urandom_range(501, 12000));
            endcase
            row = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, ROWS - 1));
            col = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, COLS - 1));
            send_pixel(depth, row, col);
         end
      end
      wait_drain();
   endtask

   always @(posedge clock) begin : check_points
      point_class_type want;
      if (!reset && rsp_strobe) begin
         if (expected_points.size() == 0) begin
            $error("result transaction with no pixel outstanding");
            errors++;
         end else begin
            want = expected_points.pop_front();
            points_checked++;
            if (want.obstacle !== rsp_obstacle) begin
               $error("obstacle: expected %0d, got %0d", want.obstacle, rsp_obstacle);
               errors++;
            end
            if (want.ground_candidate !== rsp_ground_candidate) begin
               $error("ground_candidate: expected %0d, got %0d",
                      want.ground_candidate, rsp_ground_candidate);
               errors++;
            end
            if (want.forward !== rsp_point_forward) begin
               $error("point_forward: expected %0d, got %0d", want.forward, rsp_point_forward);
               errors++;
            end
            if (want.lateral !== rsp_point_lateral) begin
               $error("point_lateral: expected %0d, got %0d", want.lateral, rsp_point_lateral);
               errors++;
            end
            if (want.height !== rsp_point_height) begin
               $error("point_height: expected %0d, got %0d", want.height, rsp_point_height);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $error("no transaction for %0d cycles", idle_cycles);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      errors = 0;
      pixels_sent = 0;
      points_checked = 0;
      settings_used = 0;
      burst_left = 0;
      gap_max = 3;
      idle_cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_depth = '0;
      req_pixel_row = '0;
      req_pixel_col = '0;
      csr_valid = 1'b0;
      csr_index = REG_FOCAL_LENGTH;
      csr_wdata = '0;
      focal_len = RST_FOCAL;
      cam_height = RST_CAMH;
      cand_limit = RST_LIMIT;
      plane_a = RST_A;
      plane_b = RST_B;
      plane_c = RST_C;
      plane_d = RST_D;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_default_settings();
      test_zero_focal_length();
      test_flat_plane_c();
      test_register_extremes();
      test_unused_index();
      test_random_traffic();

      wait_drain();
      repeat (40) @(posedge clock);
      if (expected_points.size() != 0) begin
         $error("%0d pixels never produced a result", expected_points.size());
         errors++;
      end
      $display("sent %0d pixels, checked %0d results across %0d register settings",
               pixels_sent, points_checked, settings_used);
      $display("covered invalid and infinite depth, zero focal length, flat and inverted planes");
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/dpgc_pkg.sv
sv/depth_pixel_ground_classifier.sv
tb/tb.sv
